@@ sv/evr_pkg.sv @@
// Package for the Euler vertex rotation block: field widths, register and mode
// codes, coefficient slot names, the sine-table generator and the output clamp.
// Used by every other file of the block; depends on nothing.
package evr_pkg;

  // Fixed field widths.
  localparam int unsigned IN_W        = 12;
  localparam int unsigned GAIN_W      = 16;
  localparam int unsigned OUT_W       = 28;
  localparam int unsigned OUT_FRAC    = 8;
  localparam int unsigned ANGLE_REG_W = 12;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned SAT_IN_W    = IN_W + GAIN_W + 2;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Defaults for the top-level parameters.
  localparam int unsigned ANGLE_BITS_DEF     = 12;
  localparam int unsigned SINE_FRAC_BITS_DEF = 14;

  // Number of register stages between the input and the output word.
  localparam int unsigned PIPE_DEPTH = 7;

  // Unity depth gain in Q8.8.
  localparam logic signed [GAIN_W-1:0] GAIN_ONE = 16'sd256;

  // Pi/2 in Q30 and the isometric x angle in 1/65536 turn.
  localparam longint unsigned PIH_Q30   = 64'd1686629713;
  localparam longint unsigned ISO_X_Q16 = 64'd9964;

  localparam int unsigned COEF_NUM = 6;

  typedef enum logic [MODE_W-1:0] {
    MODE_FREE     = 2'd0,
    MODE_ISO      = 2'd1,
    MODE_PARALLEL = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE    = 3'd0,
    REG_GAIN    = 3'd1,
    REG_ANGLE_Z = 3'd2,
    REG_ANGLE_X = 3'd3,
    REG_ANGLE_Y = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    COEF_SIN_Z = 3'd0,
    COEF_COS_Z = 3'd1,
    COEF_SIN_X = 3'd2,
    COEF_COS_X = 3'd3,
    COEF_SIN_Y = 3'd4,
    COEF_COS_Y = 3'd5
  } coef_slot_e;

  typedef enum logic {
    TRIG_IDLE = 1'b0,
    TRIG_RUN  = 1'b1
  } trig_state_e;

  // Quarter-wave sine sample r, evaluated only with constant arguments to
  // build the ROM. Taylor series in Q30 up to the 13th power, then rounded to
  // fb fraction bits and capped at one.
  function automatic longint unsigned sine_quarter(input longint unsigned r,
                                                   input int unsigned ab,
                                                   input int unsigned fb);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned mag;
    longint unsigned res;
    longint          sum;
    x   = (r * PIH_Q30 + ((64'd1 << (ab - 2)) >> 1)) >> (ab - 2);
    x2  = (x * x) >> 30;
    mag = x;
    sum = longint'(x);
    mag = ((mag * x2) >> 30) / 64'd6;
    sum = sum - longint'(mag);
    mag = ((mag * x2) >> 30) / 64'd20;
    sum = sum + longint'(mag);
    mag = ((mag * x2) >> 30) / 64'd42;
    sum = sum - longint'(mag);
    mag = ((mag * x2) >> 30) / 64'd72;
    sum = sum + longint'(mag);
    mag = ((mag * x2) >> 30) / 64'd110;
    sum = sum - longint'(mag);
    mag = ((mag * x2) >> 30) / 64'd156;
    sum = sum + longint'(mag);
    if (sum < 0) begin
      sum = 0;
    end
    res = (longint'(unsigned'(sum)) + (64'd1 << (29 - fb))) >> (30 - fb);
    if (res > (64'd1 << fb)) begin
      res = 64'd1 << fb;
    end
    return res;
  endfunction

  // Clamp a rotated coordinate to the output range.
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SAT_IN_W-1:0] v);
    logic signed [OUT_W-1:0] res;
    if (v[SAT_IN_W-1:OUT_W-1] == '0 || v[SAT_IN_W-1:OUT_W-1] == '1) begin
      res = v[OUT_W-1:0];
    end else if (v[SAT_IN_W-1]) begin
      res = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(OUT_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

@@ sv/evr_if.sv @@
// Handshake channels of the Euler vertex rotation block: the point input
// channel and the rotated result channel. Depends on evr_pkg for field widths.
interface evr_in_if;
  import evr_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] pos_x;
  logic signed [IN_W-1:0] pos_y;
  logic signed [IN_W-1:0] pos_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface evr_out_if;
  import evr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] out_x;
  logic signed [OUT_W-1:0] out_y;
  logic signed [OUT_W-1:0] out_z;

  modport source (output valid, output out_x, output out_y, output out_z, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z, output ready);
endinterface

@@ sv/evr_trig.sv @@
// Coefficient unit: resolves the effective angles from mode and angle
// registers and fills six sine/cosine registers from a quarter-wave ROM.
// Depends on evr_pkg.
module evr_trig #(
  parameter int unsigned ANGLE_BITS     = evr_pkg::ANGLE_BITS_DEF,
  parameter int unsigned SINE_FRAC_BITS = evr_pkg::SINE_FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [evr_pkg::MODE_W-1:0]            mode_i,
  input  logic [evr_pkg::ANGLE_REG_W-1:0]       angle_z_i,
  input  logic [evr_pkg::ANGLE_REG_W-1:0]       angle_x_i,
  input  logic [evr_pkg::ANGLE_REG_W-1:0]       angle_y_i,
  output logic                                  busy_o,
  output logic signed [SINE_FRAC_BITS+1:0]      coef_o [evr_pkg::COEF_NUM]
);
  import evr_pkg::*;

  localparam int unsigned QUARTER = 1 << (ANGLE_BITS - 2);
  localparam int unsigned IDX_W   = ANGLE_BITS - 1;
  localparam int unsigned ROM_W   = SINE_FRAC_BITS + 1;
  localparam int unsigned CW      = SINE_FRAC_BITS + 2;
  localparam longint unsigned ISO_X_FULL =
    (ISO_X_Q16 * (64'd1 << ANGLE_BITS) + 64'd32768) >> 16;
  localparam logic [ANGLE_BITS-1:0] ISO_Z = ANGLE_BITS'(QUARTER / 2);
  localparam logic [ANGLE_BITS-1:0] ISO_X = ANGLE_BITS'(ISO_X_FULL);
  localparam logic [ANGLE_BITS-1:0] QTR_A = ANGLE_BITS'(QUARTER);
  localparam logic [IDX_W-1:0]      QTR_I = IDX_W'(QUARTER);

  // Quarter-wave ROM, built at elaboration, read through a register.
  logic [ROM_W-1:0] rom [QUARTER+1];
  for (genvar i = 0; i <= QUARTER; i++) begin : g_rom
    assign rom[i] = ROM_W'(sine_quarter(longint'(i), ANGLE_BITS, SINE_FRAC_BITS));
  end

  trig_state_e           state_q, state_d;
  coef_slot_e            slot_q, slot_d;
  logic [ANGLE_BITS-1:0] eff_z, eff_x, eff_y;
  logic [ANGLE_BITS-1:0] ang, addr_ang;
  logic                  is_cos;
  logic                  issue;
  logic [IDX_W-1:0]      idx;
  logic                  neg;
  logic                  rd_v_q;
  coef_slot_e            rd_slot_q;
  logic                  rd_neg_q;
  logic [ROM_W-1:0]      rom_q;
  logic signed [CW-1:0]  mag;

  always_comb begin
    case (mode_e'(mode_i))
      MODE_ISO: begin
        eff_z = ISO_Z;
        eff_x = ISO_X;
        eff_y = '0;
      end
      MODE_PARALLEL: begin
        eff_z = '0;
        eff_x = '0;
        eff_y = '0;
      end
      default: begin
        eff_z = ANGLE_BITS'(angle_z_i);
        eff_x = ANGLE_BITS'(angle_x_i);
        eff_y = ANGLE_BITS'(angle_y_i);
      end
    endcase
  end

  // Next state: a config write restarts the sweep over all six slots.
  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    case (state_q)
      TRIG_IDLE: begin
        if (cfg_we_i) begin
          state_d = TRIG_RUN;
          slot_d  = COEF_SIN_Z;
        end
      end
      TRIG_RUN: begin
        if (cfg_we_i) begin
          slot_d = COEF_SIN_Z;
        end else if (slot_q == COEF_COS_Y) begin
          state_d = TRIG_IDLE;
          slot_d  = COEF_SIN_Z;
        end else begin
          slot_d = coef_slot_e'(slot_q + 3'd1);
        end
      end
      default: begin
        state_d = TRIG_IDLE;
        slot_d  = COEF_SIN_Z;
      end
    endcase
  end

  // Outputs: ROM address of the current slot; cosine is sine a quarter on.
  always_comb begin
    issue  = (state_q == TRIG_RUN);
    is_cos = slot_q inside {COEF_COS_Z, COEF_COS_X, COEF_COS_Y};
    case (slot_q)
      COEF_SIN_Z, COEF_COS_Z: ang = eff_z;
      COEF_SIN_X, COEF_COS_X: ang = eff_x;
      default:                ang = eff_y;
    endcase
    addr_ang = ang + (is_cos ? QTR_A : '0);
    if (addr_ang[ANGLE_BITS-2]) begin
      idx = QTR_I - IDX_W'(addr_ang[ANGLE_BITS-3:0]);
    end else begin
      idx = IDX_W'(addr_ang[ANGLE_BITS-3:0]);
    end
    neg    = addr_ang[ANGLE_BITS-1];
    busy_o = issue || rd_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TRIG_RUN;
      slot_q  <= COEF_SIN_Z;
      rd_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      rd_v_q  <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_slot_q <= slot_q;
    rd_neg_q  <= neg;
    rom_q     <= rom[idx];
  end

  assign mag = signed'({1'b0, rom_q});

  always_ff @(posedge clk_i) begin
    if (rd_v_q) begin
      coef_o[rd_slot_q] <= rd_neg_q ? -mag : mag;
    end
  end

endmodule

@@ sv/euler_vertex_rotation_unit.sv @@
// Top level of the Euler vertex rotation block: configuration registers,
// seven-stage rotation datapath and handshake control. Depends on evr_pkg,
// the channel interfaces in evr_if.sv and the coefficient unit evr_trig.
//
//   channel   dir  handshake          payload
//   in_if     in   valid / ready      pos_x, pos_y, pos_z   (12b signed integer)
//   out_if    out  valid / ready      out_x, out_y, out_z   (28b signed, 8 frac)
//   cfg       in   cfg_we_i           cfg_idx_i, cfg_data_i (write only)
//
// Throughput is one word per cycle unless the output stalls or the coefficients
// refill; there is one register stage per multiply and one per round-and-add.
// Every stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up behind a stalled output.
// After reset, and after each configuration write, in_if.ready stays low while
// the coefficient unit refills its six sine/cosine registers, one ROM read per
// cycle.
// The asynchronous active-low reset clears the valid bits and the configuration
// registers (free mode, unity gain, zero angles) and restarts the coefficient sweep.
module euler_vertex_rotation_unit #(
  parameter int unsigned ANGLE_BITS     = evr_pkg::ANGLE_BITS_DEF,
  parameter int unsigned SINE_FRAC_BITS = evr_pkg::SINE_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  evr_in_if.sink                            in_if,
  evr_out_if.source                         out_if,
  input  logic                              cfg_we_i,
  input  logic [evr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [evr_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import evr_pkg::*;

  // Coefficient width: Q1.SINE_FRAC_BITS magnitude plus sign.
  localparam int unsigned CW  = SINE_FRAC_BITS + 2;
  // x and y after scaling to 8 fraction bits; z after the depth gain.
  localparam int unsigned XW  = IN_W + OUT_FRAC;
  localparam int unsigned ZW  = IN_W + GAIN_W;
  // Coordinate widths after each rotation; each leaves room for the growth.
  localparam int unsigned R1W = XW + 2;
  localparam int unsigned R2W = ZW + 1;
  localparam int unsigned R3W = SAT_IN_W;
  // Product and sum widths per rotation.
  localparam int unsigned PW2 = CW + XW;
  localparam int unsigned SW3 = PW2 + 1;
  localparam int unsigned PW4 = CW + ZW;
  localparam int unsigned SW5 = PW4 + 1;
  localparam int unsigned PW6 = CW + R2W;
  localparam int unsigned SW7 = PW6 + 1;
  // Round-to-nearest offset, halves toward plus infinity.
  localparam longint HALF = longint'(1) << (SINE_FRAC_BITS - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes to an index outside the list are dropped.
  // ---------------------------------------------------------------------------
  logic [MODE_W-1:0]             mode_q;
  logic signed [GAIN_W-1:0]      gain_q;
  logic [ANGLE_REG_W-1:0]        angle_z_q, angle_x_q, angle_y_q;
  logic signed [GAIN_W-1:0]      gain_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_FREE;
      gain_q    <= GAIN_ONE;
      angle_z_q <= '0;
      angle_x_q <= '0;
      angle_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_MODE:    mode_q    <= cfg_data_i[MODE_W-1:0];
        REG_GAIN:    gain_q    <= signed'(cfg_data_i[GAIN_W-1:0]);
        REG_ANGLE_Z: angle_z_q <= cfg_data_i[ANGLE_REG_W-1:0];
        REG_ANGLE_X: angle_x_q <= cfg_data_i[ANGLE_REG_W-1:0];
        REG_ANGLE_Y: angle_y_q <= cfg_data_i[ANGLE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Isometric mode forces unity gain; parallel mode keeps the configured one.
  assign gain_eff = (mode_q == MODE_ISO) ? GAIN_ONE : gain_q;

  // ---------------------------------------------------------------------------
  // Sine and cosine of the three effective angles.
  // ---------------------------------------------------------------------------
  logic                 trig_busy;
  logic signed [CW-1:0] coef [COEF_NUM];

  evr_trig #(
    .ANGLE_BITS     (ANGLE_BITS),
    .SINE_FRAC_BITS (SINE_FRAC_BITS)
  ) u_trig (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .mode_i    (mode_q),
    .angle_z_i (angle_z_q),
    .angle_x_i (angle_x_q),
    .angle_y_i (angle_y_q),
    .busy_o    (trig_busy),
    .coef_o    (coef)
  );

  // ---------------------------------------------------------------------------
  // Stage control. A stage loads when it is empty or its successor loads.
  // ---------------------------------------------------------------------------
  logic [PIPE_DEPTH-1:0] v_q;
  logic [PIPE_DEPTH-1:0] en;
  logic                  in_accept;

  always_comb begin
    en[PIPE_DEPTH-1] = !v_q[PIPE_DEPTH-1] || out_if.ready;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_if.ready = en[0] && !trig_busy;
  assign in_accept   = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_accept;
      end
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath.
  // ---------------------------------------------------------------------------
  // Stage 1: x and y to 8 fraction bits, z times the Q8.8 depth gain.
  logic signed [XW-1:0]  x1_q, y1_q;
  logic signed [ZW-1:0]  z1_q;
  // Stage 2: products of the rotation about z.
  logic signed [PW2-1:0] pa2_q, pb2_q, pc2_q, pd2_q;
  logic signed [ZW-1:0]  z2_q;
  // Stage 3: x and y rotated about z.
  logic signed [SW3-1:0] sx3, sy3;
  logic signed [R1W-1:0] x3_q, y3_q;
  logic signed [ZW-1:0]  z3_q;
  // Stage 4: products of the rotation about x.
  logic signed [PW4-1:0] pa4_q, pb4_q, pc4_q, pd4_q;
  logic signed [R1W-1:0] x4_q;
  // Stage 5: y and z rotated about x.
  logic signed [SW5-1:0] sy5, sz5;
  logic signed [R2W-1:0] y5_q, z5_q;
  logic signed [R1W-1:0] x5_q;
  // Stage 6: products of the rotation about y.
  logic signed [PW6-1:0] pa6_q, pb6_q, pc6_q, pd6_q;
  logic signed [R2W-1:0] y6_q;
  // Stage 7: x and z rotated about y, all three clamped; this is the output.
  logic signed [SW7-1:0] sx7, sz7;
  logic signed [OUT_W-1:0] x7_q, y7_q, z7_q;

  always_comb begin
    sx3 = SW3'(pa2_q) - SW3'(pb2_q) + SW3'(HALF);
    sy3 = SW3'(pc2_q) + SW3'(pd2_q) + SW3'(HALF);
    sy5 = SW5'(pa4_q) - SW5'(pb4_q) + SW5'(HALF);
    sz5 = SW5'(pc4_q) + SW5'(pd4_q) + SW5'(HALF);
    sx7 = SW7'(pa6_q) - SW7'(pb6_q) + SW7'(HALF);
    sz7 = SW7'(pc6_q) + SW7'(pd6_q) + SW7'(HALF);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      x1_q <= XW'(in_if.pos_x) <<< OUT_FRAC;
      y1_q <= XW'(in_if.pos_y) <<< OUT_FRAC;
      z1_q <= ZW'(in_if.pos_z) * ZW'(gain_eff);
    end
    if (en[1]) begin
      pa2_q <= PW2'(coef[COEF_COS_Z]) * PW2'(x1_q);
      pb2_q <= PW2'(coef[COEF_SIN_Z]) * PW2'(y1_q);
      pc2_q <= PW2'(coef[COEF_SIN_Z]) * PW2'(x1_q);
      pd2_q <= PW2'(coef[COEF_COS_Z]) * PW2'(y1_q);
      z2_q  <= z1_q;
    end
    if (en[2]) begin
      x3_q <= R1W'(sx3 >>> SINE_FRAC_BITS);
      y3_q <= R1W'(sy3 >>> SINE_FRAC_BITS);
      z3_q <= z2_q;
    end
    if (en[3]) begin
      pa4_q <= PW4'(coef[COEF_COS_X]) * PW4'(y3_q);
      pb4_q <= PW4'(coef[COEF_SIN_X]) * PW4'(z3_q);
      pc4_q <= PW4'(coef[COEF_SIN_X]) * PW4'(y3_q);
      pd4_q <= PW4'(coef[COEF_COS_X]) * PW4'(z3_q);
      x4_q  <= x3_q;
    end
    if (en[4]) begin
      y5_q <= R2W'(sy5 >>> SINE_FRAC_BITS);
      z5_q <= R2W'(sz5 >>> SINE_FRAC_BITS);
      x5_q <= x4_q;
    end
    if (en[5]) begin
      pa6_q <= PW6'(coef[COEF_COS_Y]) * PW6'(x5_q);
      pb6_q <= PW6'(coef[COEF_SIN_Y]) * PW6'(z5_q);
      pc6_q <= PW6'(coef[COEF_SIN_Y]) * PW6'(x5_q);
      pd6_q <= PW6'(coef[COEF_COS_Y]) * PW6'(z5_q);
      y6_q  <= y5_q;
    end
    if (en[6]) begin
      x7_q <= sat_out(R3W'(sx7 >>> SINE_FRAC_BITS));
      z7_q <= sat_out(R3W'(sz7 >>> SINE_FRAC_BITS));
      y7_q <= sat_out(R3W'(y6_q));
    end
  end

  assign out_if.valid = v_q[PIPE_DEPTH-1];
  assign out_if.out_x = x7_q;
  assign out_if.out_y = y7_q;
  assign out_if.out_z = z7_q;

endmodule

@@ sv/evr_checker.sv @@
// Port-level checker for the Euler vertex rotation block, bound to the top
// level. Depends on evr_pkg for widths and the pipeline depth.
module evr_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [evr_pkg::OUT_W-1:0]  out_x_i,
  input logic signed [evr_pkg::OUT_W-1:0]  out_y_i,
  input logic signed [evr_pkg::OUT_W-1:0]  out_z_i,
  input logic                              cfg_we_i
);
  import evr_pkg::*;

  localparam int unsigned CNT_W = $clog2(PIPE_DEPTH + 1);

  logic             in_acc, out_acc;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Words accepted at the input and not yet delivered.
  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (out_acc && !in_acc) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_x_i) &&
                                    $stable(out_y_i) && $stable(out_z_i))
    else $error("result word changed while stalled");

  // No result appears without a word in flight.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0)
    else $error("result word without an accepted input word");

  // With every stage full, a new word only enters as one leaves.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && cnt_q == CNT_W'(PIPE_DEPTH) |-> out_acc)
    else $error("input word accepted while the pipeline is full");

  // A configuration write holds off input while the coefficients refill.
  a_cfg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_ready_i ##6 !in_ready_i)
    else $error("input accepted during coefficient refill");

endmodule

bind euler_vertex_rotation_unit evr_checker u_evr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_x_i     (out_if.out_x),
  .out_y_i     (out_if.out_y),
  .out_z_i     (out_if.out_z),
  .cfg_we_i    (cfg_we_i)
);

@@ dv/tb_top.sv @@
// Self-checking testbench for euler_vertex_rotation_unit: drives map points, writes
// the rotation registers between phases and checks every rotated word against a
// local fixed-point model. Depends on evr_pkg and the channels in evr_if.sv.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import evr_pkg::*;

  // The block is built with its default angle and sine resolutions, and the
  // local model below follows the same two numbers.
  localparam int unsigned AB           = ANGLE_BITS_DEF;
  localparam int unsigned SFB          = SINE_FRAC_BITS_DEF;
  localparam int unsigned QUARTER_TURN = 1 << (AB - 2);
  localparam longint      ROUND_HALF   = longint'(1) << (SFB - 1);

  // Isometric mode forces an eighth of a turn about z and about 54.74 degrees
  // about x, both rounded to the angle resolution.
  localparam logic [AB-1:0] ISO_ANGLE_Z = AB'(1 << (AB - 3));
  localparam logic [AB-1:0] ISO_ANGLE_X =
    AB'((ISO_X_Q16 * (64'd1 << AB) + 64'd32768) >> 16);

  // The fourth mode code has no name in the package and behaves as free rotation.
  localparam logic [MODE_W-1:0]    MODE_SPARE      = 2'd3;
  // Register indexes from here up to the top of the index range are unmapped.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd5;

  localparam logic signed [IN_W-1:0]   POS_MAX  = {1'b0, {(IN_W-1){1'b1}}};
  localparam logic signed [IN_W-1:0]   POS_MIN  = {1'b1, {(IN_W-1){1'b0}}};
  localparam logic [CFG_DATA_W-1:0]    GAIN_MAX = 16'h7FFF;
  localparam logic [CFG_DATA_W-1:0]    GAIN_MIN = 16'h8000;
  localparam logic [CFG_DATA_W-1:0]    ALL_ONES = 16'hFFFF;

  localparam int unsigned CLK_HALF     = 10;
  localparam int unsigned RESET_CYCLES = 6;
  // Limit on how long no word may stay stuck; the longest legal quiet stretch
  // is the deliberate output hold, which is far shorter.
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 80;

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
  } rotated_t;

  // One coordinate pair after a plane rotation, still at full precision.
  typedef struct packed {
    longint p;
    longint q;
  } plane_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  evr_in_if  pt_in ();
  evr_out_if pt_out ();

  euler_vertex_rotation_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_if      (pt_in),
    .out_if     (pt_out),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Local copy of the register file, updated as each write goes out.
  logic [MODE_W-1:0]        mode_sh = MODE_FREE;
  logic signed [GAIN_W-1:0] gain_sh = GAIN_ONE;
  logic [AB-1:0]            az_sh   = '0;
  logic [AB-1:0]            ax_sh   = '0;
  logic [AB-1:0]            ay_sh   = '0;

  // Quarter-wave sine samples, filled once before reset is released.
  longint   sine_rom [0:QUARTER_TURN];
  // Rotated points still owed by the block, oldest first.
  rotated_t rotated_q [$];

  int unsigned fail_count     = 0;
  int unsigned checked_count  = 0;
  int unsigned sent_count     = 0;
  int unsigned setting_count  = 0;
  int unsigned quiet_cycles   = 0;
  bit          tx_idle_en     = 1'b0;
  bit          rx_idle_en     = 1'b0;
  int unsigned rx_hold_cycles = 0;

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point model of the rotation
  // ---------------------------------------------------------------------------

  // Sine of r quarter-turn steps in Q1.SFB: a Taylor series in Q30 up to the
  // thirteenth power, rounded half up and capped at one.
  function automatic longint quarter_sine(input int unsigned r);
    longint unsigned ang;
    longint unsigned ang2;
    longint unsigned term;
    longint unsigned res;
    longint          acc;
    int              n;
    ang  = (longint'(r) * PIH_Q30 + (QUARTER_TURN / 2)) >> (AB - 2);
    ang2 = (ang * ang) >> 30;
    term = ang;
    acc  = longint'(ang);
    for (n = 1; n <= 6; n++) begin
      term = ((term * ang2) >> 30) / longint'((2 * n) * (2 * n + 1));
      acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
    end
    if (acc < 0) begin
      acc = 0;
    end
    res = acc;
    res = (res + (64'd1 << (29 - SFB))) >> (30 - SFB);
    if (res > (64'd1 << SFB)) begin
      res = 64'd1 << SFB;
    end
    return longint'(res);
  endfunction

  // Full-turn sine by quadrant symmetry; cosine is the sine a quarter turn on.
  function automatic longint sine_of(input logic [AB-1:0] a);
    logic [1:0]  quad;
    int unsigned r;
    longint      mag;
    quad = a[AB-1 -: 2];
    r    = 32'(a[AB-3:0]);
    mag  = quad[0] ? sine_rom[QUARTER_TURN - r] : sine_rom[r];
    return quad[1] ? -mag : mag;
  endfunction

  // Rotates (p, q) by angle a: c*p - s*q and s*p + c*q, each rounded once.
  function automatic plane_t plane_turn(input longint p, input longint q,
                                        input logic [AB-1:0] a);
    longint s;
    longint c;
    plane_t t;
    s   = sine_of(a);
    c   = sine_of(AB'(a + QUARTER_TURN));
    t.p = (c * p - s * q + ROUND_HALF) >>> SFB;
    t.q = (s * p + c * q + ROUND_HALF) >>> SFB;
    return t;
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_out(input longint v);
    longint top;
    longint bottom;
    top    = (longint'(1) << (OUT_W - 1)) - 1;
    bottom = -(longint'(1) << (OUT_W - 1));
    if (v > top) begin
      v = top;
    end else if (v < bottom) begin
      v = bottom;
    end
    return v[OUT_W-1:0];
  endfunction

  // Expected output word for one point under the current register settings.
  function automatic rotated_t rotate_point(input logic signed [IN_W-1:0] px,
                                            input logic signed [IN_W-1:0] py,
                                            input logic signed [IN_W-1:0] pz);
    longint        vx;
    longint        vy;
    longint        vz;
    longint        gain;
    logic [AB-1:0] az;
    logic [AB-1:0] ax;
    logic [AB-1:0] ay;
    plane_t        t;
    rotated_t      r;
    vx   = longint'(px) * (longint'(1) << OUT_FRAC);
    vy   = longint'(py) * (longint'(1) << OUT_FRAC);
    gain = longint'(gain_sh);
    az   = az_sh;
    ax   = ax_sh;
    ay   = ay_sh;
    case (mode_sh)
      MODE_ISO: begin
        gain = longint'(GAIN_ONE);
        az   = ISO_ANGLE_Z;
        ax   = ISO_ANGLE_X;
        ay   = '0;
      end
      MODE_PARALLEL: begin
        az = '0;
        ax = '0;
        ay = '0;
      end
      default: ;
    endcase
    // The Q8.8 gain puts z straight onto the 8-bit fraction grid.
    vz = longint'(pz) * gain;
    t  = plane_turn(vx, vy, az);
    vx = t.p;
    vy = t.q;
    t  = plane_turn(vy, vz, ax);
    vy = t.p;
    vz = t.q;
    t  = plane_turn(vx, vz, ay);
    vx = t.p;
    vz = t.q;
    r.x = clamp_out(vx);
    r.y = clamp_out(vy);
    r.z = clamp_out(vz);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // A coordinate with a bias toward both ends of the range.
  function automatic logic signed [IN_W-1:0] pick_coord();
    logic signed [IN_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = POS_MIN;
      1:       v = POS_MAX;
      default: v = IN_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = GAIN_MIN;
      1:       v = GAIN_MAX;
      2:       v = GAIN_ONE;
      default: v = CFG_DATA_W'($urandom);
    endcase
    return v;
  endfunction

  // Angle write data: the upper bits beyond the angle width are random too,
  // since the block must drop them.
  function automatic logic [CFG_DATA_W-1:0] pick_angle();
    logic [CFG_DATA_W-1:0] v;
    v = CFG_DATA_W'($urandom);
    case ($urandom_range(0, 5))
      0:       v[AB-1:0] = '0;
      1:       v[AB-1:0] = '1;
      default: ;
    endcase
    return v;
  endfunction

  // Writes one register. The enable is high for exactly one rising edge and
  // the next write always starts on a later falling edge.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we   <= 1'b0;
    case (idx)
      REG_MODE:    mode_sh = data[MODE_W-1:0];
      REG_GAIN:    gain_sh = data;
      REG_ANGLE_Z: az_sh   = data[AB-1:0];
      REG_ANGLE_X: ax_sh   = data[AB-1:0];
      REG_ANGLE_Y: ay_sh   = data[AB-1:0];
      default: ;
    endcase
  endtask

  // Offers one point and returns at the edge that accepts it. Valid stays high
  // into the next call unless that call opens an idle gap first.
  task automatic send_point(input logic signed [IN_W-1:0] px,
                            input logic signed [IN_W-1:0] py,
                            input logic signed [IN_W-1:0] pz);
    int unsigned gap;
    @(negedge clk);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      pt_in.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pt_in.valid <= 1'b1;
    pt_in.pos_x <= px;
    pt_in.pos_y <= py;
    pt_in.pos_z <= pz;
    do @(posedge clk); while (pt_in.ready !== 1'b1);
    rotated_q.push_back(rotate_point(px, py, pz));
    sent_count++;
  endtask

  task automatic send_random_points(input int unsigned count);
    repeat (count) send_point(pick_coord(), pick_coord(), pick_coord());
  endtask

  // Stops offering and waits until every owed word has come back. Since each
  // point yields exactly one word, the block is idle once the queue is empty.
  task automatic drain_results();
    @(negedge clk);
    pt_in.valid <= 1'b0;
    while (rotated_q.size() != 0) @(posedge clk);
  endtask

  // A fresh random setting of every register, sometimes with a stray write to
  // an unmapped index mixed in.
  task automatic random_settings();
    cfg_write(REG_MODE, CFG_DATA_W'($urandom));
    cfg_write(REG_GAIN, pick_gain());
    cfg_write(REG_ANGLE_Z, pick_angle());
    cfg_write(REG_ANGLE_X, pick_angle());
    cfg_write(REG_ANGLE_Y, pick_angle());
    if ($urandom_range(0, 3) == 0) begin
      cfg_write(CFG_IDX_W'(REG_UNMAPPED_LO + $urandom_range(0, 2)),
                CFG_DATA_W'($urandom));
    end
    setting_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: free mode, unity gain and zero angles pass points through
  // scaled by 256, including both corners of the input range.
  task automatic test_reset_values();
    setting_count++;
    send_point('0, '0, '0);
    send_point(POS_MAX, POS_MAX, POS_MAX);
    send_point(POS_MIN, POS_MIN, POS_MIN);
    send_point(POS_MIN, POS_MAX, 12'sd1);
    drain_results();
  endtask

  // Largest and most negative gains against the largest heights, with angles
  // on the quadrant boundaries, one step from them and midway between them. The
  // first and last angle writes of the second setting carry junk above the angle width.
  task automatic test_gain_and_angle_extremes();
    cfg_write(REG_GAIN, GAIN_MAX);
    cfg_write(REG_ANGLE_Z, CFG_DATA_W'(QUARTER_TURN));
    cfg_write(REG_ANGLE_X, CFG_DATA_W'(2 * QUARTER_TURN));
    cfg_write(REG_ANGLE_Y, CFG_DATA_W'(3 * QUARTER_TURN));
    setting_count++;
    send_point(POS_MAX, POS_MIN, POS_MAX);
    send_point(POS_MIN, POS_MAX, POS_MIN);
    drain_results();
    cfg_write(REG_GAIN, GAIN_MIN);
    cfg_write(REG_ANGLE_Z, ALL_ONES);
    cfg_write(REG_ANGLE_X, 16'd1);
    cfg_write(REG_ANGLE_Y, {4'hF, 12'(QUARTER_TURN / 2)});
    setting_count++;
    send_point(POS_MIN, POS_MIN, POS_MIN);
    send_point(POS_MAX, POS_MAX, POS_MAX);
    drain_results();
  endtask

  // Isometric mode must ignore both the stored gain and the stored angles,
  // parallel mode only the angles, and the spare code acts as free rotation.
  task automatic test_modes();
    cfg_write(REG_MODE, CFG_DATA_W'(MODE_ISO));
    setting_count++;
    send_point(POS_MAX, POS_MIN, POS_MAX);
    send_point(12'sd100, -12'sd37, 12'sd5);
    send_point(POS_MIN, POS_MIN, POS_MIN);
    drain_results();
    cfg_write(REG_MODE, CFG_DATA_W'(MODE_PARALLEL));
    setting_count++;
    send_point(POS_MAX, POS_MAX, POS_MIN);
    send_point(-12'sd1, 12'sd1, POS_MAX);
    drain_results();
    cfg_write(REG_MODE, CFG_DATA_W'(MODE_SPARE));
    setting_count++;
    send_point(POS_MIN, POS_MAX, POS_MAX);
    send_point(12'sd3, 12'sd700, -12'sd900);
    drain_results();
  endtask

  // Writes to the unmapped indexes must leave every register as it was.
  task automatic test_unmapped_writes();
    int unsigned i;
    for (i = REG_UNMAPPED_LO; i < (1 << CFG_IDX_W); i++) begin
      cfg_write(CFG_IDX_W'(i), ALL_ONES);
    end
    send_point(POS_MAX, POS_MIN, -12'sd1);
    send_point(12'sd1, POS_MAX, POS_MIN);
    drain_results();
  endtask

  // Random settings and random points, each phase with its own idling mix so
  // that some phases run without gaps on one side or both.
  task automatic test_random_phases(input int unsigned phases, input int unsigned per_phase);
    repeat (phases) begin
      random_settings();
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      send_random_points(per_phase);
      drain_results();
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // back to back, so the pipeline fills and input ready has to drop.
  task automatic test_output_hold();
    random_settings();
    tx_idle_en     = 1'b0;
    rx_idle_en     = 1'b0;
    rx_hold_cycles = HOLD_CYCLES;
    send_random_points(40);
    drain_results();
  endtask

  // The sender stops in the middle of a setting and waits until every word has
  // come out before it carries on with the same registers.
  task automatic test_sender_pause();
    random_settings();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    send_random_points(15);
    drain_results();
    send_random_points(15);
    drain_results();
  endtask

  // Last part of the run: full rate on both sides with no idling at all.
  task automatic test_full_rate_tail();
    random_settings();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_random_points(60);
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: ready changes only at falling edges. A requested hold is counted
  // here; otherwise short random stall bursts come while idling is enabled.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned gap;
    pt_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles != 0) begin
        pt_out.ready <= 1'b0;
        repeat (rx_hold_cycles) @(negedge clk);
        rx_hold_cycles = 0;
        pt_out.ready  <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 3);
        pt_out.ready <= 1'b0;
        repeat (gap) @(negedge clk);
        pt_out.ready <= 1'b1;
      end else begin
        pt_out.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every word that leaves the block is compared field by field with
  // the oldest owed point.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rotated_t want;
    if (rst_n && pt_out.valid === 1'b1 && pt_out.ready === 1'b1) begin
      if (rotated_q.size() == 0) begin
        $error("output word with no point owed: x=%0d y=%0d z=%0d",
               pt_out.out_x, pt_out.out_y, pt_out.out_z);
        fail_count++;
      end else begin
        want = rotated_q.pop_front();
        checked_count++;
        if (pt_out.out_x !== want.x) begin
          $error("out_x mismatch: expected %0d, got %0d", want.x, pt_out.out_x);
          fail_count++;
        end
        if (pt_out.out_y !== want.y) begin
          $error("out_y mismatch: expected %0d, got %0d", want.y, pt_out.out_y);
          fail_count++;
        end
        if (pt_out.out_z !== want.z) begin
          $error("out_z mismatch: expected %0d, got %0d", want.z, pt_out.out_z);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: counts consecutive cycles in which no word moves on either side.
  // ---------------------------------------------------------------------------
  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((pt_in.valid === 1'b1 && pt_in.ready === 1'b1) ||
          (pt_out.valid === 1'b1 && pt_out.ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $error("no word moved for %0d cycles, %0d words still owed", STALL_LIMIT,
           rotated_q.size());
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned r;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_data    = '0;
    pt_in.valid = 1'b0;
    pt_in.pos_x = '0;
    pt_in.pos_y = '0;
    pt_in.pos_z = '0;
    for (r = 0; r <= QUARTER_TURN; r++) begin
      sine_rom[r] = quarter_sine(r);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part first, all with both sides idling at random.
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_reset_values();
    test_gain_and_angle_extremes();
    test_modes();
    test_unmapped_writes();

    test_random_phases(10, 30);
    test_output_hold();
    test_sender_pause();
    test_full_rate_tail();

    // Nothing is owed any more; give the pipeline time to show a stray word.
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (rotated_q.size() != 0) begin
      $error("%0d expected words never arrived", rotated_q.size());
      fail_count++;
    end

    $display("Rotated %0d points under %0d register settings (all four mode codes,",
             sent_count, setting_count);
    $display("gain and angle extremes, unmapped writes, stalls on both sides); %0d words checked.",
             checked_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
